/* design/cfsr_pkg.sv */
// shared types and constants for the colour frequency sensor reader
package cfsr_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_WB   = 2'd2;

    // S2S3 filter select codes
    localparam logic [1:0] PINS_RED   = 2'd0;
    localparam logic [1:0] PINS_GREEN = 2'd3;
    localparam logic [1:0] PINS_BLUE  = 2'd1;
    localparam logic [1:0] PINS_CLEAR = 2'd2;

    // channel numbers of a result
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // configuration register indexes and widths
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_MS    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_SCALE = 2'd1;

    // reset values
    localparam logic [9:0] GATE_MS_RESET    = 10'd10;
    localparam logic [1:0] FREQ_SCALE_RESET = 2'd3;
    localparam int RED_FACTOR_RESET   = 205;
    localparam int GREEN_FACTOR_RESET = 195;
    localparam int BLUE_FACTOR_RESET  = 255;

    // colour value limits
    localparam logic [7:0] VALUE_MAX  = 8'd255;
    localparam logic [7:0] VALUE_NONE = 8'd0;

    // job queue between front and back, depth is a power of two
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    // restoring divider: one quotient bit per step, nine bits with saturation
    localparam int Q_BITS = 9;
    localparam logic [3:0] DIV_FIRST_STEP = 4'd8;
    localparam logic [3:0] DIV_LAST_STEP  = 4'd0;

    // sequence mode of the front
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_READ = 3'b010,
        MODE_WB   = 3'b100
    } t_mode;

    // state of the back
    typedef enum logic [1:0] {
        BK_TAKE = 2'b01,
        BK_DIV  = 2'b10
    } t_back_state;

    // input item request
    typedef struct packed {
        logic [1:0] operation;
        logic       edge_req;
        logic       ms_tick;
    } t_item;

    // result request
    typedef struct packed {
        logic [1:0] filter_select;
        logic [1:0] scale_pins;
        logic       led_on;
        logic       busy_res;
        logic       result_valid;
        logic [1:0] channel;
        logic [7:0] value;
        logic       is_last;
    } t_result;

    // everything of a result except the value, passed from front to back
    typedef struct packed {
        logic [1:0] filter_select;
        logic [1:0] scale_pins;
        logic       led_on;
        logic       busy_res;
        logic       result_valid;
        logic [1:0] channel;
        logic       is_last;
    } t_job_meta;

    localparam int META_BITS = $bits(t_job_meta);

endpackage

/* design/cfsr_front.sv */
// front: config registers, filter sequencing, edge counting, job building
module cfsr_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cfsr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [cfsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_accept,
    input  cfsr_pkg::t_item                     i_item,
    output cfsr_pkg::t_job_meta                 o_meta,
    output logic [COUNT_BITS-1:0]               o_count,
    output logic [COUNT_BITS-1:0]               o_factor
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [9:0]            r_gate_ms;
    logic [1:0]            r_freq_scale;
    logic [COUNT_BITS-1:0] r_edge_count, n_edge_count;
    logic [9:0]            r_window_ms, n_window_ms;
    logic [1:0]            r_channel, n_channel;
    cfsr_pkg::t_mode       r_mode, n_mode;
    logic [COUNT_BITS-1:0] r_red, n_red;
    logic [COUNT_BITS-1:0] r_green, n_green;
    logic [COUNT_BITS-1:0] r_blue, n_blue;

    logic [COUNT_BITS-1:0] cnt_edge;
    logic [9:0]            win_inc;
    logic [9:0]            gate_eff;
    logic [1:0]            ch_c;
    logic                  close_win;
    logic [COUNT_BITS-1:0] factor_sel;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_ms    <= cfsr_pkg::GATE_MS_RESET;
            r_freq_scale <= cfsr_pkg::FREQ_SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cfsr_pkg::REG_GATE_MS:    r_gate_ms    <= i_cfg_data[9:0];
                cfsr_pkg::REG_FREQ_SCALE: r_freq_scale <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // per-item datapath pieces
    always_comb begin
        cnt_edge = (i_item.edge_req && r_edge_count != COUNT_MAX)
                 ? r_edge_count + COUNT_BITS'(1) : r_edge_count;
        win_inc   = r_window_ms + 10'd1;
        gate_eff  = (r_gate_ms == 10'd0) ? 10'd1 : r_gate_ms;
        close_win = i_item.ms_tick && (win_inc >= gate_eff);
        ch_c      = (r_channel > cfsr_pkg::CH_BLUE) ? cfsr_pkg::CH_BLUE : r_channel;
        case (ch_c)
            cfsr_pkg::CH_RED:   factor_sel = r_red;
            cfsr_pkg::CH_GREEN: factor_sel = r_green;
            default:            factor_sel = r_blue;
        endcase
    end

    // sequence step
    always_comb begin
        n_edge_count = r_edge_count;
        n_window_ms  = r_window_ms;
        n_channel    = r_channel;
        n_mode       = r_mode;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        o_meta.result_valid = 1'b0;
        o_meta.channel      = cfsr_pkg::CH_RED;
        o_meta.is_last      = 1'b0;
        o_count             = cnt_edge;
        o_factor            = factor_sel;
        if (r_mode == cfsr_pkg::MODE_IDLE) begin
            if (i_item.operation == cfsr_pkg::OP_READ ||
                i_item.operation == cfsr_pkg::OP_WB) begin
                n_mode = (i_item.operation == cfsr_pkg::OP_READ)
                       ? cfsr_pkg::MODE_READ : cfsr_pkg::MODE_WB;
                n_channel    = cfsr_pkg::CH_RED;
                n_edge_count = '0;
                n_window_ms  = '0;
            end
        end else begin
            n_edge_count = cnt_edge;
            if (i_item.ms_tick) begin
                n_window_ms = win_inc;
            end
            if (close_win) begin
                if (r_mode == cfsr_pkg::MODE_READ) begin
                    o_meta.result_valid = 1'b1;
                    o_meta.channel      = ch_c;
                    o_meta.is_last      = (ch_c == cfsr_pkg::CH_BLUE);
                end else begin
                    case (ch_c)
                        cfsr_pkg::CH_RED:   n_red   = cnt_edge;
                        cfsr_pkg::CH_GREEN: n_green = cnt_edge;
                        default:            n_blue  = cnt_edge;
                    endcase
                end
                n_edge_count = '0;
                n_window_ms  = '0;
                if (ch_c == cfsr_pkg::CH_BLUE) begin
                    n_mode    = cfsr_pkg::MODE_IDLE;
                    n_channel = cfsr_pkg::CH_RED;
                end else begin
                    n_channel = ch_c + 2'd1;
                end
            end
        end

        // pin outputs follow the state after this item
        if (n_mode == cfsr_pkg::MODE_IDLE) begin
            o_meta.filter_select = cfsr_pkg::PINS_CLEAR;
        end else begin
            case (n_channel)
                cfsr_pkg::CH_RED:   o_meta.filter_select = cfsr_pkg::PINS_RED;
                cfsr_pkg::CH_GREEN: o_meta.filter_select = cfsr_pkg::PINS_GREEN;
                default:            o_meta.filter_select = cfsr_pkg::PINS_BLUE;
            endcase
        end
        o_meta.scale_pins = r_freq_scale;
        o_meta.led_on     = (n_mode == cfsr_pkg::MODE_WB);
        o_meta.busy_res   = (n_mode != cfsr_pkg::MODE_IDLE);
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_window_ms  <= '0;
            r_channel    <= cfsr_pkg::CH_RED;
            r_mode       <= cfsr_pkg::MODE_IDLE;
            r_red        <= COUNT_BITS'(cfsr_pkg::RED_FACTOR_RESET);
            r_green      <= COUNT_BITS'(cfsr_pkg::GREEN_FACTOR_RESET);
            r_blue       <= COUNT_BITS'(cfsr_pkg::BLUE_FACTOR_RESET);
        end else if (i_accept) begin
            r_edge_count <= n_edge_count;
            r_window_ms  <= n_window_ms;
            r_channel    <= n_channel;
            r_mode       <= n_mode;
            r_red        <= n_red;
            r_green      <= n_green;
            r_blue       <= n_blue;
        end
    end

endmodule

/* design/cfsr_fifo.sv */
// short job queue between the front and the back
module cfsr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0]                   r_mem [cfsr_pkg::FIFO_DEPTH];
    logic [cfsr_pkg::FIFO_PTR_BITS-1:0] r_wr;
    logic [cfsr_pkg::FIFO_PTR_BITS-1:0] r_rd;
    logic [cfsr_pkg::FIFO_CNT_BITS-1:0] r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == cfsr_pkg::FIFO_CNT_BITS'(cfsr_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers wrap naturally at the power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + cfsr_pkg::FIFO_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + cfsr_pkg::FIFO_PTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + cfsr_pkg::FIFO_CNT_BITS'(1);
                2'b01:   r_count <= r_count - cfsr_pkg::FIFO_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // fill level never passes the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cfsr_pkg::FIFO_CNT_BITS'(cfsr_pkg::FIFO_DEPTH))
        else $error("queue fill level above depth");

endmodule

/* design/cfsr_back.sv */
// back: balance division and the result output register
module cfsr_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_empty,
    input  cfsr_pkg::t_job_meta   i_meta,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COUNT_BITS-1:0] i_factor,
    output logic                  o_job_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output cfsr_pkg::t_result     o_result
);

    localparam int REM_BITS = COUNT_BITS + 8;

    cfsr_pkg::t_back_state           r_state;
    logic                            r_ovalid;
    cfsr_pkg::t_result               r_out;
    cfsr_pkg::t_job_meta             r_meta;
    logic [REM_BITS-1:0]             r_rem;
    logic [COUNT_BITS-1:0]           r_den;
    logic [cfsr_pkg::Q_BITS-1:0]     r_q;
    logic [3:0]                      r_step;

    logic                            slot_free;
    logic                            take;
    logic                            needs_div;
    logic [REM_BITS-1:0]             prod;
    logic [REM_BITS-1:0]             den_sh;
    logic                            fits;
    logic [cfsr_pkg::Q_BITS-1:0]     q_next;
    logic [7:0]                      q_value;
    logic                            finish;

    // handshake with the queue and the output slot
    assign slot_free = !r_ovalid || i_pop;
    assign take      = !i_job_empty && (r_state == cfsr_pkg::BK_TAKE) && slot_free;
    assign o_job_pop = take;
    assign needs_div = i_meta.result_valid && (i_factor != '0);
    assign o_empty   = !r_ovalid;
    assign o_result  = r_out;

    // count * 255 as a shift and subtract
    assign prod = {i_count, 8'd0} - {8'd0, i_count};

    // one restoring division step
    always_comb begin
        den_sh  = {8'd0, r_den} << r_step;
        fits    = (r_rem >= den_sh);
        q_next  = fits ? (r_q | (cfsr_pkg::Q_BITS'(1) << r_step)) : r_q;
        q_value = q_next[cfsr_pkg::Q_BITS-1] ? cfsr_pkg::VALUE_MAX : q_next[7:0];
        finish  = (r_state == cfsr_pkg::BK_DIV) &&
                  (r_step == cfsr_pkg::DIV_LAST_STEP) && slot_free;
    end

    // divider sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsr_pkg::BK_TAKE;
        end else begin
            case (r_state)
                cfsr_pkg::BK_TAKE: begin
                    if (take && needs_div) begin
                        r_state <= cfsr_pkg::BK_DIV;
                    end
                end
                cfsr_pkg::BK_DIV: begin
                    if (finish) begin
                        r_state <= cfsr_pkg::BK_TAKE;
                    end
                end
                default: r_state <= cfsr_pkg::BK_TAKE;
            endcase
        end
    end

    // divider datapath, the last step waits for a free output slot
    always_ff @(posedge i_clk) begin
        if (take && needs_div) begin
            r_meta <= i_meta;
            r_rem  <= prod;
            r_den  <= i_factor;
            r_q    <= '0;
            r_step <= cfsr_pkg::DIV_FIRST_STEP;
        end else if (r_state == cfsr_pkg::BK_DIV && r_step != cfsr_pkg::DIV_LAST_STEP) begin
            if (fits) begin
                r_rem <= r_rem - den_sh;
            end
            r_q    <= q_next;
            r_step <= r_step - 4'd1;
        end
    end

    // output slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((take && !needs_div) || finish) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    // output slot payload
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out.filter_select <= r_meta.filter_select;
            r_out.scale_pins    <= r_meta.scale_pins;
            r_out.led_on        <= r_meta.led_on;
            r_out.busy_res      <= r_meta.busy_res;
            r_out.result_valid  <= r_meta.result_valid;
            r_out.channel       <= r_meta.channel;
            r_out.is_last       <= r_meta.is_last;
            r_out.value         <= q_value;
        end else if (take && !needs_div) begin
            r_out.filter_select <= i_meta.filter_select;
            r_out.scale_pins    <= i_meta.scale_pins;
            r_out.led_on        <= i_meta.led_on;
            r_out.busy_res      <= i_meta.busy_res;
            r_out.result_valid  <= i_meta.result_valid;
            r_out.channel       <= i_meta.channel;
            r_out.is_last       <= i_meta.is_last;
            r_out.value         <= i_meta.result_valid ? cfsr_pkg::VALUE_MAX
                                                       : cfsr_pkg::VALUE_NONE;
        end
    end

    // step counter stays within the quotient bits
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfsr_pkg::BK_DIV) |-> (r_step <= cfsr_pkg::DIV_FIRST_STEP))
        else $error("divider step out of range");

    // a division is never started with a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfsr_pkg::BK_DIV) |-> (r_den != '0))
        else $error("divider running with zero factor");

    // a result without a colour value shows zero value and no last mark
    a_idle_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.result_valid) |->
        (r_out.value == cfsr_pkg::VALUE_NONE && !r_out.is_last))
        else $error("value shown without a colour result");

endmodule

/* design/colour_frequency_sensor_reader.sv */
// top level of the colour frequency sensor reader with white balance
//
//  channel   handshake                  payload
//  item      push / full                i_item   (operation, edge_req, ms_tick)
//  result    pop / empty                o_result (pins, flags, channel, value)
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item is taken per cycle while the job queue has room; each gives one result
// a result is registered in the output slot after its item leaves the job queue;
// a read closing a window runs the restoring divider, one quotient bit per cycle
// the four-entry job queue and the output register let either side stall alone
// synchronous active-low reset restores config, factors and sequence state
module colour_frequency_sensor_reader #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  cfsr_pkg::t_item                     i_item,
    input  logic                                pop,
    output logic                                empty,
    output cfsr_pkg::t_result                   o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cfsr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [cfsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int JOB_BITS = cfsr_pkg::META_BITS + 2 * COUNT_BITS;

    logic                  accept;
    cfsr_pkg::t_job_meta   front_meta;
    logic [COUNT_BITS-1:0] front_count;
    logic [COUNT_BITS-1:0] front_factor;
    logic [JOB_BITS-1:0]   job_in;
    logic [JOB_BITS-1:0]   job_out;
    logic                  job_empty;
    logic                  job_pop;
    cfsr_pkg::t_job_meta   back_meta;
    logic [COUNT_BITS-1:0] back_count;
    logic [COUNT_BITS-1:0] back_factor;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // front end
    cfsr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_meta      (front_meta),
        .o_count     (front_count),
        .o_factor    (front_factor)
    );

    // job queue
    assign job_in = {front_meta, front_count, front_factor};

    cfsr_fifo #(
        .WIDTH (JOB_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    assign {back_meta, back_count, back_factor} = job_out;

    // back end
    cfsr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_meta      (back_meta),
        .i_count     (back_count),
        .i_factor    (back_factor),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
